// ===== hw/rtl/bsh64_pkg.sv =====
package bsh64_pkg;

  // Constant added after the final avalanche
  localparam logic [63:0] HASH_OFFSET = 64'h0000_0000_1000_0000;

  // Byte count held in a partial group, 0..3
  localparam int GPOS_W = 2;

  // One finished string handed from the byte gatherer to the finish pipeline
  typedef struct packed {
    logic [63:0]       hash;
    logic [23:0]       pend;
    logic [GPOS_W-1:0] count;
  } tail_req_t;

  // Arithmetic right shift of a 64-bit word
  function automatic logic [63:0] asr64(input logic [63:0] x, input int n);
    return $signed(x) >>> n;
  endfunction

  // One avalanche step: xor in a left shift, then add an arithmetic right shift
  function automatic logic [63:0] aval_step(input logic [63:0] h, input int shl,
                                            input int shr);
    logic [63:0] t;
    t = h ^ (h << shl);
    return t + asr64(t, shr);
  endfunction

endpackage

// ===== hw/rtl/bsh64_fin_pipe.sv =====
module bsh64_fin_pipe (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  bsh64_pkg::tail_req_t req,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [63:0]          out_hash
);
  import bsh64_pkg::*;

  localparam int NSTG = 6;

  logic [NSTG-1:0]   v_r;
  logic [63:0]       h_r [NSTG];
  logic [23:0]       s0_pend_r;
  logic [GPOS_W-1:0] s0_cnt_r;
  logic [7:0]        s1_b2_r;
  logic [GPOS_W-1:0] s1_cnt_r;
  logic              out_valid_r;
  logic [63:0]       out_hash_r;
  logic [NSTG:0]     rdy;
  logic [63:0]       addend;
  logic [63:0]       mix_h;
  logic [63:0]       tail3;

  // Stage may load when empty or when its successor moves on
  always_comb begin
    rdy[NSTG] = !out_valid_r || out_ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign req_ready = rdy[0];

  // Select the tail bytes that fold into the hash
  always_comb begin
    unique case (s0_cnt_r)
      2'd0:    addend = '0;
      2'd1:    addend = {56'b0, s0_pend_r[7:0]};
      default: addend = {48'b0, s0_pend_r[15:0]};
    endcase
  end

  // Three leftover bytes: fold in the shifted hash and the third byte
  assign tail3 = h_r[1] ^ (h_r[1] << 16) ^ ({56'b0, s1_b2_r} << 18);

  // Finish the tail rule for the leftover byte count
  always_comb begin
    unique case (s1_cnt_r)
      2'd3:    mix_h = tail3 + asr64(tail3, 11);
      2'd2:    mix_h = aval_step(h_r[1], 11, 17);
      2'd1:    mix_h = aval_step(h_r[1], 10, 1);
      default: mix_h = h_r[1];
    endcase
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy[0]) v_r[0] <= req_valid;
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
      if (rdy[NSTG]) out_valid_r <= v_r[NSTG-1];
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (rdy[0] && req_valid) begin
      h_r[0]    <= req.hash;
      s0_pend_r <= req.pend;
      s0_cnt_r  <= req.count;
    end
    if (rdy[1] && v_r[0]) begin
      h_r[1]   <= h_r[0] + addend;
      s1_b2_r  <= s0_pend_r[23:16];
      s1_cnt_r <= s0_cnt_r;
    end
    if (rdy[2] && v_r[1]) h_r[2] <= mix_h;
    if (rdy[3] && v_r[2]) h_r[3] <= aval_step(h_r[2], 3, 5);
    if (rdy[4] && v_r[3]) h_r[4] <= aval_step(h_r[3], 4, 17);
    if (rdy[5] && v_r[4]) h_r[5] <= aval_step(h_r[4], 25, 6);
    if (rdy[NSTG] && v_r[NSTG-1]) out_hash_r <= h_r[NSTG-1] + HASH_OFFSET;
  end

  assign out_valid = out_valid_r;
  assign out_hash  = out_hash_r;

  // A stalled last stage keeps its word
  a_last_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NSTG-1] && !rdy[NSTG] |=> v_r[NSTG-1] && $stable(h_r[NSTG-1]))
    else $error("finish pipeline dropped a stalled word");

endmodule

// ===== hw/rtl/byte_string_hash_64_top.sv =====
// Byte string hash, 64-bit: one byte per transfer, the first transfer of a string carries
// its length as seed. The block takes one byte every cycle, back to back, unless the finish
// pipeline stalls in_ready; the round-to-round dependence closes through a single 64-bit
// add per cycle, since the sum of the hash and the two low group bytes is prepared when the
// second byte arrives. The hash transfer appears on out_valid after the last byte passes
// the capture register, the tail and avalanche stages (one 64-bit add each) and the output
// register; the output register lets input continue while a result waits.
// An empty string (first with length zero) yields its hash the same way.
module byte_string_hash_64_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  input  logic               in_first,
  input  logic               in_last,
  input  logic [31:0]        in_length,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] out_hash_value
);
  import bsh64_pkg::*;

  logic              acc;
  logic [63:0]       run_hash_r, run_hash_nxt;
  logic [23:0]       pend_r, pend_nxt;
  logic [GPOS_W-1:0] gpos_r, gpos_nxt;
  logic              in_str_r, in_str_nxt;
  logic [63:0]       pre_sum_r, pre_sum_nxt;
  logic [63:0]       h_e;
  logic [23:0]       p_e;
  logic [GPOS_W-1:0] g_e;
  logic              live;
  logic [63:0]       rnd_t, rnd_h2, rnd_h3;
  logic [23:0]       p_g;
  logic [63:0]       h_n;
  logic [23:0]       p_n;
  logic [GPOS_W-1:0] g_n;
  logic              req_valid, req_ready;
  tail_req_t         req;
  logic [63:0]       out_hash;

  assign acc      = in_valid && in_ready;
  assign in_ready = req_ready;

  // Effective state: a first transfer restarts from the length seed
  assign h_e  = in_first ? {32'b0, in_length} : run_hash_r;
  assign p_e  = in_first ? 24'b0 : pend_r;
  assign g_e  = in_first ? '0 : gpos_r;
  assign live = in_first ? (in_length != 32'b0) : in_str_r;

  // Full-group round on the fourth byte
  assign rnd_t  = {37'b0, in_data_byte, p_e[23:16], 11'b0} ^ pre_sum_r;
  assign rnd_h2 = {pre_sum_r[47:0], 16'b0} ^ rnd_t;
  assign rnd_h3 = rnd_h2 + asr64(rnd_h2, 11);

  // Gather a byte into the partial group
  assign p_g = p_e | (24'(in_data_byte) << {g_e, 3'b000});

  always_comb begin
    if (g_e == 2'd3) begin
      h_n = rnd_h3;
      p_n = '0;
      g_n = '0;
    end else begin
      h_n = h_e;
      p_n = p_g;
      g_n = g_e + 2'd1;
    end
  end

  // Update string state and hand finished strings on
  always_comb begin
    run_hash_nxt = run_hash_r;
    pend_nxt     = pend_r;
    gpos_nxt     = gpos_r;
    in_str_nxt   = in_str_r;
    pre_sum_nxt  = pre_sum_r;
    req_valid    = 1'b0;
    req          = '{hash: h_n, pend: p_n, count: g_n};
    if (acc) begin
      priority if (in_first && in_length == 32'b0) begin
        req_valid    = 1'b1;
        req          = '{hash: '0, pend: '0, count: '0};
        run_hash_nxt = '0;
        pend_nxt     = '0;
        gpos_nxt     = '0;
        in_str_nxt   = 1'b0;
      end else if (live) begin
        if (g_e == 2'd1) pre_sum_nxt = h_e + {48'b0, in_data_byte, p_e[7:0]};
        if (in_last) begin
          req_valid    = 1'b1;
          run_hash_nxt = '0;
          pend_nxt     = '0;
          gpos_nxt     = '0;
          in_str_nxt   = 1'b0;
        end else begin
          run_hash_nxt = h_n;
          pend_nxt     = p_n;
          gpos_nxt     = g_n;
          in_str_nxt   = 1'b1;
        end
      end else begin
        // drop a stray byte outside any string
        in_str_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_hash_r <= '0;
      pend_r     <= '0;
      gpos_r     <= '0;
      in_str_r   <= 1'b0;
    end else begin
      run_hash_r <= run_hash_nxt;
      pend_r     <= pend_nxt;
      gpos_r     <= gpos_nxt;
      in_str_r   <= in_str_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pre_sum_r <= pre_sum_nxt;
  end

  bsh64_fin_pipe u_fin (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_hash  (out_hash)
  );

  assign out_hash_value = $signed(out_hash);

  // Partial bytes only exist inside an open string
  a_gpos_open: assert property (@(posedge clk) disable iff (!rst_n)
    gpos_r != 2'd0 |-> in_str_r)
    else $error("partial group held with no open string");

  // A last byte always closes the string
  a_last_close: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_last |=> !in_str_r && gpos_r == 2'd0)
    else $error("string left open after last byte");

  // Results are only launched by a transfer, and an empty string always launches one
  a_req_src: assert property (@(posedge clk) disable iff (!rst_n)
    req_valid |-> acc)
    else $error("hash request without input transfer");

  a_empty_req: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_first && in_length == 32'b0 |-> req_valid)
    else $error("empty string gave no hash request");

endmodule

// ===== tb/byte_string_hash_64_top_tb.sv =====
module byte_string_hash_64_top_tb;
  import bsh64_pkg::HASH_OFFSET;

  localparam int ITEMS_PER_PHASE = 530;
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = 16;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int SHOW_MAX        = 20;

  // Track the string hash as bytes are accepted and hold the hashes still owed
  class hash_scoreboard;
    logic [63:0] run_hash;
    logic [23:0] held;
    logic [1:0]  held_cnt;
    bit          str_open;
    logic [63:0] hash_queue[$];
    int          errors;
    int          checked;

    function new();
      run_hash = '0;
      held     = '0;
      held_cnt = '0;
      str_open = 1'b0;
      errors   = 0;
      checked  = 0;
    endfunction

    function logic [63:0] arith_shr(logic [63:0] x, int n);
      logic signed [63:0] s;
      s = x;
      return s >>> n;
    endfunction

    function logic [63:0] avalanche(logic [63:0] h);
      h ^= h << 3;
      h += arith_shr(h, 5);
      h ^= h << 4;
      h += arith_shr(h, 17);
      h ^= h << 25;
      h += arith_shr(h, 6);
      return h + HASH_OFFSET;
    endfunction

    // Mix the one to three bytes left over when the string closes
    function logic [63:0] mix_tail(logic [63:0] h);
      logic [63:0] b0, b1, b2;
      b0 = 64'(held[7:0]);
      b1 = 64'(held[15:8]);
      b2 = 64'(held[23:16]);
      case (held_cnt)
        2'd3: begin
          h += (b1 << 8) + b0;
          h ^= h << 16;
          h ^= b2 << 18;
          h += arith_shr(h, 11);
        end
        2'd2: begin
          h += (b1 << 8) + b0;
          h ^= h << 11;
          h += arith_shr(h, 17);
        end
        2'd1: begin
          h += b0;
          h ^= h << 10;
          h += arith_shr(h, 1);
        end
        default: ;
      endcase
      return h;
    endfunction

    function void note_input(logic [7:0] b, bit is_first, bit is_last, logic [31:0] len);
      logic [63:0] h, t;
      if (is_first) begin
        run_hash = {32'b0, len};
        held     = '0;
        held_cnt = '0;
        // empty string: hash of zero right away, nothing stays open
        if (len == 32'd0) begin
          str_open = 1'b0;
          hash_queue.push_back(avalanche(64'd0));
          return;
        end
        str_open = 1'b1;
      end else if (!str_open) begin
        return;
      end

      // Fourth byte completes a group: run one round
      if (held_cnt == 2'd3) begin
        h = run_hash + 64'(held[15:0]);
        t = (64'({b, held[23:16]}) << 11) ^ h;
        h = (h << 16) ^ t;
        h += arith_shr(h, 11);
        run_hash = h;
        held     = '0;
        held_cnt = '0;
      end else begin
        held[held_cnt*8 +: 8] = b;
        held_cnt = held_cnt + 2'd1;
      end

      if (is_last) begin
        hash_queue.push_back(avalanche(mix_tail(run_hash)));
        run_hash = '0;
        held     = '0;
        held_cnt = '0;
        str_open = 1'b0;
      end
    endfunction

    task log_mismatch(string msg);
      errors++;
      if (errors <= SHOW_MAX) $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task check_result(logic [63:0] got);
      logic [63:0] want;
      if (hash_queue.size() == 0) begin
        log_mismatch($sformatf("hash %h with none outstanding", got));
        return;
      end
      want = hash_queue.pop_front();
      checked++;
      if (got !== want)
        log_mismatch($sformatf("hash_value got %h want %h", got, want));
    endtask

    function int pending();
      return hash_queue.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_data_byte = '0;
  logic               in_first = 1'b0;
  logic               in_last = 1'b0;
  logic [31:0]        in_length = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [63:0] out_hash_value;

  hash_scoreboard sb = new();

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_grant  = 0;
  int hold_seen   = 0;
  int hold_left   = 0;
  int cycle_count = 0;
  int strings_sent = 0;
  int items_sent   = 0;
  int stray_sent   = 0;

  byte_string_hash_64_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_first       (in_first),
    .in_last        (in_last),
    .in_length      (in_length),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hash_value (out_hash_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d hashes outstanding", cycle_count, sb.pending());
      $display("Some tests failed");
      $finish;
    end
  end

  // Drive out_ready: long hold-off on request, random stalls otherwise
  always @(posedge clk) begin
    if (hold_grant != hold_seen) begin
      hold_seen <= hold_grant;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Note each input transfer and check each hash transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_input(in_data_byte, in_first, in_last, in_length);
      if (out_valid && out_ready)
        sb.check_result(out_hash_value);
    end
  end

  // Offer one item and hold it until the transfer; valid stays high for the caller
  task automatic send_item(input logic [7:0] b, input bit is_first, input bit is_last,
                           input logic [31:0] len);
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_first     <= is_first;
    in_last      <= is_last;
    in_length    <= len;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic maybe_pause();
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Pause the sender until every owed hash has come back
  task automatic drain_hashes();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // One string with random bytes; sometimes empty, mis-seeded, cut short or
  // preceded by stray bytes
  task automatic send_random_string(inout int n_items);
    int n, cnt;
    bit cut_short;
    logic [31:0] seed_len;
    if ($urandom_range(99) < 5) begin
      repeat ($urandom_range(1, 3)) begin
        maybe_pause();
        send_item(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)), $urandom);
        stray_sent++;
      end
    end
    strings_sent++;
    if ($urandom_range(99) < 8) begin
      maybe_pause();
      send_item(8'($urandom_range(255)), 1'b1, 1'($urandom_range(1)), 32'd0);
      n_items++;
      return;
    end
    n = ($urandom_range(99) < 75) ? $urandom_range(1, 12) : $urandom_range(13, 48);
    seed_len = ($urandom_range(99) < 10) ? $urandom : n;
    cut_short = ($urandom_range(99) < 6);
    cnt = cut_short ? $urandom_range(1, n) : n;
    for (int i = 0; i < cnt; i++) begin
      maybe_pause();
      send_item(8'($urandom_range(255)), i == 0, !cut_short && (i == n - 1),
                (i == 0) ? seed_len : $urandom);
    end
    n_items += cnt;
  endtask

  initial begin
    int phase_items;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty string, stray byte, every tail count, full group,
    // longest seed, restart while open, empty while open
    send_item(8'hFF, 1'b1, 1'b1, 32'd0);
    send_item(8'hAA, 1'b0, 1'b1, 32'hFFFF_FFFF);
    send_item(8'hFF, 1'b1, 1'b1, 32'd1);
    send_item(8'h00, 1'b1, 1'b0, 32'd2);
    send_item(8'hFF, 1'b0, 1'b1, 32'h5555_5555);
    send_item(8'h80, 1'b1, 1'b0, 32'd3);
    send_item(8'h7F, 1'b0, 1'b0, 32'd0);
    send_item(8'hFF, 1'b0, 1'b1, 32'd0);
    send_item(8'hFF, 1'b1, 1'b0, 32'hFFFF_FFFF);
    send_item(8'hFF, 1'b0, 1'b0, 32'd0);
    send_item(8'hFF, 1'b0, 1'b0, 32'd0);
    send_item(8'hFF, 1'b0, 1'b1, 32'd0);
    send_item(8'h12, 1'b1, 1'b0, 32'd7);
    send_item(8'h34, 1'b0, 1'b0, 32'd0);
    send_item(8'h56, 1'b1, 1'b0, 32'd3);
    send_item(8'h78, 1'b0, 1'b0, 32'd0);
    send_item(8'h9A, 1'b0, 1'b1, 32'd0);
    send_item(8'h01, 1'b1, 1'b0, 32'd9);
    send_item(8'h02, 1'b1, 1'b0, 32'd0);
    send_item(8'hC3, 1'b1, 1'b0, 32'd5);
    send_item(8'h3C, 1'b0, 1'b0, 32'd0);
    send_item(8'hA5, 1'b0, 1'b0, 32'd0);
    send_item(8'h5A, 1'b0, 1'b0, 32'd0);
    send_item(8'hE7, 1'b0, 1'b1, 32'd0);
    items_sent = 24;
    drain_hashes();

    // Random strings under three idle mixes
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 58 : 0;
      rx_idle_pct <= (ph == 0) ? 58 : (ph == 1) ? 32 : 0;
      if (ph != 1) hold_grant <= hold_grant + 1;
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) send_random_string(phase_items);
      items_sent += phase_items;
      drain_hashes();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.log_mismatch($sformatf("%0d hashes never arrived", sb.pending()));

    $display("Covered %0d strings in %0d items plus %0d stray bytes; %0d hashes checked",
             strings_sent, items_sent, stray_sent, sb.checked);
    $display("Ran sender-heavy, receiver-heavy and no-idle mixes with long output stalls");
    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
